### hdl/hcbd_pkg.sv
// Shared types, constants and helper functions for the chunked body decoder.
package hcbd_pkg;

   localparam int SIZE_BITS = 31;
   localparam int LIMIT_BITS = 31;
   localparam int COUNT_BITS = 32;
   localparam int BYTE_BITS = 8;

   localparam logic [BYTE_BITS-1:0] CHAR_CR = 8'h0D;
   localparam logic [BYTE_BITS-1:0] CHAR_LF = 8'h0A;

   // Configuration register indexes.
   localparam logic CSR_LIMIT_ENABLE = 1'b0;
   localparam logic CSR_BODY_LIMIT = 1'b1;

   localparam logic [LIMIT_BITS-1:0] BODY_LIMIT_RESET = 31'd1048576;

   // Request kinds carried in req_tuser.
   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_START = 1'b1;

   typedef enum logic [2:0] {
      PH_SIZE  = 3'd0,
      PH_LF    = 3'd1,
      PH_DATA  = 3'd2,
      PH_SKIP1 = 3'd3,
      PH_SKIP2 = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_RUN    = 2'd0,
      ST_DONE   = 2'd1,
      ST_BADHDR = 2'd2,
      ST_BIG    = 2'd3
   } status_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_digit_type;

   // Decodes one ASCII hex digit; ok is low for any other character.
   function automatic hex_digit_type hex_decode(input logic [BYTE_BITS-1:0] c);
      hex_digit_type d;
      d.ok = 1'b1;
      d.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d.value = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d.value = 4'(c - 8'h37);
      end else begin
         d.ok = 1'b0;
      end
      return d;
   endfunction

endpackage

### hdl/http_chunked_body_decoder.sv
// Chunked transfer decoder for an HTTP/1.1 body, one raw byte per request.
//
// Usage: raw body bytes enter on the req_ stream, req_tdata holding the byte
// and req_tuser the kind (0 = body byte, 1 = start a new body). Every request
// gives exactly one response on the rsp_ stream: rsp_tdata is the decoded
// payload byte, rsp_tuser holds the payload flag and the body status
// (running, complete, bad chunk header, too large). Size lines, their CR LF
// and the two bytes after each chunk give responses with the flag low.
// The csr_ port writes limit_enable (index 0) and body_limit (index 1); write
// it only while no request is in flight.
//
// A request passes an input register, then the phase update and the response
// register. Throughput is one request per cycle while the receiver takes
// responses, since each byte needs only one pass of the phase logic. When the
// receiver stalls, the response register holds and the input register still
// takes one more request, if it is empty, before req_tready drops.
// Reset clears the decoder state, sets limit_enable to 0 and body_limit to
// 1048576; no memory is cleared, so requests are taken as soon as reset ends.
module http_chunked_body_decoder
   import hcbd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_BITS-1:0]  req_tdata,   // [7:0] body_byte
   input  logic                  req_tuser,   // [0] func

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [BYTE_BITS-1:0]  rsp_tdata,   // [7:0] out_byte
   output logic [2:0]            rsp_tuser,   // [0] out_valid, [2:1] status

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [LIMIT_BITS-1:0] csr_data
);

   logic                  limit_enable_ff;
   logic [LIMIT_BITS-1:0] body_limit_ff;

   logic                  req_valid_ff, req_valid_in;
   logic                  req_func_ff;
   logic [BYTE_BITS-1:0]  req_byte_ff;

   phase_type             phase_ff, phase_in;
   logic [SIZE_BITS-1:0]  size_accum_ff, size_accum_in;
   logic [SIZE_BITS-1:0]  data_left_ff, data_left_in;
   logic [COUNT_BITS-1:0] raw_count_ff, raw_count_in;
   status_type            final_status_ff, final_status_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_flag_ff, rsp_flag_in;
   logic [BYTE_BITS-1:0]  rsp_byte_ff, rsp_byte_in;
   status_type            rsp_status_ff;

   logic                  rsp_free;
   logic                  process;
   hex_digit_type         digit;
   logic [SIZE_BITS-1:0]  data_dec;

   assign csr_ready  = 1'b1;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign process    = req_valid_ff && rsp_free;
   assign req_tready = !req_valid_ff || rsp_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = {rsp_status_ff, rsp_flag_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_enable_ff <= 1'b0;
         body_limit_ff <= BODY_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_LIMIT_ENABLE) begin
            limit_enable_ff <= csr_data[0];
         end else begin
            body_limit_ff <= csr_data;
         end
      end
   end

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_tready) begin
         req_valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_func_ff <= req_tuser;
         req_byte_ff <= req_tdata;
      end
   end

   assign digit = hex_decode(req_byte_ff);
   assign data_dec = (data_left_ff != '0) ? data_left_ff - SIZE_BITS'(1) : data_left_ff;

   always_comb begin
      phase_in = phase_ff;
      size_accum_in = size_accum_ff;
      data_left_in = data_left_ff;
      raw_count_in = raw_count_ff;
      final_status_in = final_status_ff;
      rsp_flag_in = 1'b0;
      rsp_byte_in = '0;

      if (process) begin
         if (req_func_ff == FUNC_START) begin
            phase_in = PH_SIZE;
            size_accum_in = '0;
            data_left_in = '0;
            raw_count_in = '0;
            final_status_in = ST_RUN;
         end else if (final_status_ff == ST_RUN) begin
            if (raw_count_ff != '1) begin
               raw_count_in = raw_count_ff + COUNT_BITS'(1);
            end
            if (limit_enable_ff &&
                raw_count_in > COUNT_BITS'(body_limit_ff)) begin
               final_status_in = ST_BIG;
            end else begin
               unique case (phase_ff)
                  PH_SIZE: begin
                     if (req_byte_ff == CHAR_CR) begin
                        phase_in = PH_LF;
                     end else if (!digit.ok) begin
                        final_status_in = ST_BADHDR;
                     end else if (size_accum_ff[SIZE_BITS-1 -: 4] != 4'd0) begin
                        // Another digit would shift bits out of the size field.
                        final_status_in = ST_BADHDR;
                     end else begin
                        size_accum_in = {size_accum_ff[SIZE_BITS-5:0], digit.value};
                     end
                  end
                  PH_LF: begin
                     if (req_byte_ff != CHAR_LF) begin
                        final_status_in = ST_BADHDR;
                     end else if (size_accum_ff == '0) begin
                        final_status_in = ST_DONE;
                     end else begin
                        data_left_in = size_accum_ff;
                        size_accum_in = '0;
                        phase_in = PH_DATA;
                     end
                  end
                  PH_DATA: begin
                     rsp_flag_in = 1'b1;
                     rsp_byte_in = req_byte_ff;
                     data_left_in = data_dec;
                     if (data_dec == '0) begin
                        phase_in = PH_SKIP1;
                     end
                  end
                  PH_SKIP1: begin
                     phase_in = PH_SKIP2;
                  end
                  default: begin
                     phase_in = PH_SIZE;
                     size_accum_in = '0;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SIZE;
         size_accum_ff <= '0;
         data_left_ff <= '0;
         raw_count_ff <= '0;
         final_status_ff <= ST_RUN;
      end else begin
         phase_ff <= phase_in;
         size_accum_ff <= size_accum_in;
         data_left_ff <= data_left_in;
         raw_count_ff <= raw_count_in;
         final_status_ff <= final_status_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_free) begin
         rsp_valid_in = req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         rsp_flag_ff <= rsp_flag_in;
         rsp_byte_ff <= rsp_byte_in;
         rsp_status_ff <= final_status_in;
      end
   end

   // A payload byte only leaves while the body is still running.
   a_flag_running: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tuser[2:1] == ST_RUN)
      else $error("payload byte with a final status");

   // Non-payload responses carry a zero byte.
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("nonzero byte without payload flag");

   // A final status holds until a new body is started.
   a_status_held: assert property (@(posedge clock) disable iff (reset)
      process && req_func_ff == FUNC_BYTE && final_status_ff != ST_RUN
      |=> $stable(final_status_ff))
      else $error("final status changed without a new body");

   // The data phase is left only once the chunk is used up.
   a_data_exit: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA && phase_in == PH_SKIP1 |-> data_left_in == '0)
      else $error("chunk data phase left early");

endmodule
